>>> rtl/lmls_pkg.sv
// Shared types and constants for the LCD mode line sequencer.
package lmls_pkg;

  typedef enum logic [2:0] {
    PH_OFF      = 3'd0,
    PH_OAM      = 3'd1,
    PH_XFER     = 3'd2,
    PH_HBL_OAM  = 3'd3,
    PH_HBL_VBL  = 3'd4,
    PH_VBL_LINE = 3'd5,
    PH_VBL_OAM  = 3'd6
  } phase_t;

  localparam logic [2:0] ACT_TICK     = 3'd0;
  localparam logic [2:0] ACT_CTRL     = 3'd1;
  localparam logic [2:0] ACT_CMP      = 3'd2;
  localparam logic [2:0] ACT_LINE_RST = 3'd3;
  localparam logic [2:0] ACT_STAT_EN  = 3'd4;

  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // STAT enable bits
  localparam int EN_HBLANK = 0;
  localparam int EN_VBLANK = 1;
  localparam int EN_OAM    = 2;
  localparam int EN_LYC    = 3;

  localparam logic [7:0] OAM_TICKS  = 8'd20;
  localparam logic [7:0] XFER_TICKS = 8'd43;
  localparam logic [7:0] HBL_TICKS  = 8'd51;
  localparam logic [7:0] LINE_TICKS = 8'd114;

  localparam logic [7:0] LINE_LAST_VIS  = 8'd143;
  localparam logic [7:0] LINE_VBL_FIRST = 8'd144;
  localparam logic [7:0] LINE_LAST      = 8'd153;

  localparam logic [7:0] RST_COUNTDOWN = 8'd71;
  localparam logic [7:0] RST_CTRL      = 8'h91;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] countdown;
    logic [7:0] line;
    logic [7:0] cmp;
    logic [7:0] ctrl;
    logic [3:0] stat_en;
    logic       coinc;
  } state_t;

  typedef struct packed {
    logic [7:0] line;
    logic [1:0] mode;
    logic       coinc;
    logic       stat_req;
    logic       vblank_irq;
    logic       hblank_start;
    logic       frame_ready;
  } res_t;

endpackage

>>> rtl/lcd_mode_line_sequencer_core.sv
// LCD scanline mode sequencer top level: input register, step logic, result register.
// A word accepted into the input register moves on to the result register and the out_ ports
// once that register is free; a stalled result word holds it in the input register.
// Throughput: one word per cycle while out_stall does not hold a valid result word; the step
// logic between the input and result registers is combinational.
// Reset (synchronous, rst_n low): display on, line 144 in vblank with 71 ticks left,
module lcd_mode_line_sequencer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_action,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_line,
  output logic [1:0] out_mode,
  output logic       out_coincidence,
  output logic       out_stat_irq,
  output logic       out_vblank_irq,
  output logic       out_hblank_start,
  output logic       out_frame_ready
);
  // speed factor 1, compare line 0, STAT enables clear, both registers empty.
  import lmls_pkg::*;

  logic       sf_r;
  logic       in_vld_r;
  logic [2:0] in_action_r;
  logic [7:0] in_value_r;
  state_t     state_r;
  state_t     state_nxt;
  res_t       res_nxt;
  res_t       res_r;
  logic       out_vld_r;
  logic       advance;

  // double speed when factor is 2 or 3
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_r <= 1'b0;
    end else if (cfg_wr_en) begin
      sf_r <= cfg_wr_data[1];
    end
  end

  assign advance  = in_vld_r & ~(out_vld_r & out_stall);
  assign in_stall = in_vld_r & ~advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_action_r <= in_action;
      in_value_r  <= in_value;
    end
  end

  lmls_step u_step (
    .cur    (state_r),
    .action (in_action_r),
    .value  (in_value_r),
    .dbl    (sf_r),
    .nxt    (state_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase     <= PH_VBL_LINE;
      state_r.countdown <= RST_COUNTDOWN;
      state_r.line      <= LINE_VBL_FIRST;
      state_r.cmp       <= 8'd0;
      state_r.ctrl      <= RST_CTRL;
      state_r.stat_en   <= 4'd0;
      state_r.coinc     <= 1'b0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  // hold the result word while stalled
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_line         = res_r.line;
  assign out_mode         = res_r.mode;
  assign out_coincidence  = res_r.coinc;
  assign out_stat_irq     = res_r.stat_req;
  assign out_vblank_irq   = res_r.vblank_irq;
  assign out_hblank_start = res_r.hblank_start;
  assign out_frame_ready  = res_r.frame_ready;

  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> res_r.line <= LINE_LAST)
    else $error("line counter out of range");

  a_vblank_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.vblank_irq) |->
      (res_r.mode == MODE_VBLANK && res_r.frame_ready))
    else $error("vblank pulse away from vblank entry");

  a_hblank_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.hblank_start) |-> res_r.mode == MODE_HBLANK)
    else $error("hblank strobe outside hblank");

  a_off_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_OFF) == !state_r.ctrl[7])
    else $error("sequencer run state disagrees with display enable");

endmodule

>>> rtl/lmls_step.sv
// Next-state and result logic for one sequencer word.
module lmls_step (
  input  lmls_pkg::state_t cur,
  input  logic [2:0]       action,
  input  logic [7:0]       value,
  input  logic             dbl,
  output lmls_pkg::state_t nxt,
  output lmls_pkg::res_t   res
);
  import lmls_pkg::*;

  logic [7:0] line_inc;
  logic       match_inc;
  logic       match_zero;
  logic       match_wr;
  logic       disp_on;
  logic [7:0] oam_len;
  logic [7:0] xfer_len;
  logic [7:0] hbl_len;
  logic [7:0] line_len;
  logic       stat;
  logic       vbl;
  logic       hbl;
  logic       frame;
  logic [1:0] mode;

  assign line_inc   = (cur.line == LINE_LAST) ? 8'd0 : cur.line + 8'd1;
  assign match_inc  = (line_inc == cur.cmp);
  assign match_zero = (cur.cmp == 8'd0);
  assign match_wr   = (cur.line == value);
  assign disp_on    = cur.ctrl[7];

  assign oam_len  = dbl ? {OAM_TICKS[6:0], 1'b0}  : OAM_TICKS;
  assign xfer_len = dbl ? {XFER_TICKS[6:0], 1'b0} : XFER_TICKS;
  assign hbl_len  = dbl ? {HBL_TICKS[6:0], 1'b0}  : HBL_TICKS;
  assign line_len = dbl ? {LINE_TICKS[6:0], 1'b0} : LINE_TICKS;

  always_comb begin
    nxt   = cur;
    stat  = 1'b0;
    vbl   = 1'b0;
    hbl   = 1'b0;
    frame = 1'b0;
    case (action)
      ACT_TICK: begin
        if (cur.phase != PH_OFF) begin
          if (cur.countdown > 8'd1) begin
            nxt.countdown = cur.countdown - 8'd1;
          end else begin
            case (cur.phase)
              PH_OAM: begin
                nxt.phase     = PH_XFER;
                nxt.countdown = xfer_len;
              end
              PH_XFER: begin
                stat          = disp_on & cur.stat_en[EN_HBLANK];
                hbl           = 1'b1;
                nxt.phase     = (cur.line == LINE_LAST_VIS) ? PH_HBL_VBL : PH_HBL_OAM;
                nxt.countdown = hbl_len;
              end
              PH_HBL_OAM, PH_VBL_OAM: begin
                nxt.line      = line_inc;
                nxt.coinc     = match_inc;
                stat          = disp_on & ((match_inc & cur.stat_en[EN_LYC]) |
                                           cur.stat_en[EN_OAM]);
                nxt.phase     = PH_OAM;
                nxt.countdown = oam_len;
              end
              PH_HBL_VBL: begin
                nxt.line      = line_inc;
                nxt.coinc     = match_inc;
                stat          = disp_on & ((match_inc & cur.stat_en[EN_LYC]) |
                                           cur.stat_en[EN_VBLANK]);
                vbl           = 1'b1;
                frame         = 1'b1;
                nxt.phase     = PH_VBL_LINE;
                nxt.countdown = line_len;
              end
              PH_VBL_LINE: begin
                nxt.line      = line_inc;
                nxt.coinc     = match_inc;
                stat          = disp_on & match_inc & cur.stat_en[EN_LYC];
                nxt.phase     = (line_inc == LINE_LAST) ? PH_VBL_OAM : PH_VBL_LINE;
                nxt.countdown = line_len;
              end
              default: begin
              end
            endcase
          end
        end
      end
      ACT_CTRL: begin
        nxt.ctrl = value;
        if (!(cur.ctrl[7] & value[7])) begin
          if (value[7]) begin
            // enable: compare checked while still off, so no interrupt
            nxt.line      = 8'd0;
            nxt.coinc     = match_zero;
            nxt.phase     = PH_OAM;
            nxt.countdown = oam_len - 8'd1;
          end else if (cur.ctrl[7]) begin
            // disable: compare may still fire, then drop flag and stop
            nxt.line      = 8'd0;
            stat          = match_zero & cur.stat_en[EN_LYC];
            nxt.coinc     = 1'b0;
            nxt.phase     = PH_OFF;
            nxt.countdown = 8'd0;
          end
        end
      end
      ACT_CMP: begin
        nxt.cmp   = value;
        nxt.coinc = match_wr;
        stat      = disp_on & match_wr & cur.stat_en[EN_LYC];
      end
      ACT_LINE_RST: begin
        nxt.line  = 8'd0;
        nxt.coinc = match_zero;
        stat      = disp_on & match_zero & cur.stat_en[EN_LYC];
      end
      ACT_STAT_EN: begin
        nxt.stat_en = value[6:3];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (nxt.phase)
      PH_OAM:                  mode = MODE_OAM;
      PH_XFER:                 mode = MODE_XFER;
      PH_VBL_LINE, PH_VBL_OAM: mode = MODE_VBLANK;
      default:                 mode = MODE_HBLANK;
    endcase
  end

  assign res.line         = nxt.line;
  assign res.mode         = mode;
  assign res.coinc        = nxt.coinc;
  assign res.stat_req     = stat;
  assign res.vblank_irq   = vbl;
  assign res.hblank_start = hbl;
  assign res.frame_ready  = frame;

endmodule

>>> verif/tb.sv
// Testbench for the LCD mode line sequencer: predicts every status word and checks the result stream.
`timescale 1ns / 1ps

module tb;
  import lmls_pkg::*;

  localparam int          HALF_PERIOD      = 4;
  localparam int          RESET_CYCLES     = 11;
  localparam int          WAIT_MAX         = 19;
  localparam int          RANDOM_WORDS     = 100;
  localparam int          TICK_RUN         = 280;
  localparam logic [2:0]  ACT_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]  ACT_UNUSED_LAST  = 3'd7;
  localparam logic [7:0]  LINE_COUNT       = 8'd154;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] value;
  } word_t;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       cfg_wr_en   = 1'b0;
  logic [1:0] cfg_wr_data = 2'd0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [2:0] in_action   = ACT_TICK;
  logic [7:0] in_value    = 8'd0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [7:0] out_line;
  logic [1:0] out_mode;
  logic       out_coincidence;
  logic       out_stat_irq;
  logic       out_vblank_irq;
  logic       out_hblank_start;
  logic       out_frame_ready;

  // predicted sequencer state, reset values
  logic [1:0] tick_scale = 2'd1;
  phase_t     lcd_phase  = PH_VBL_LINE;
  logic [7:0] ticks_left = RST_COUNTDOWN;
  logic [7:0] ly         = LINE_VBL_FIRST;
  logic [7:0] lyc        = 8'd0;
  logic [7:0] lcdc       = RST_CTRL;
  logic [3:0] stat_en    = 4'd0;
  logic       ly_match   = 1'b0;
  logic       stat_pulse;

  word_t pending_words[$];
  res_t  status_due[$];
  int    feed_odds    = 16;
  int    drain_odds   = 16;
  int    feed_wait    = 0;
  int    drain_wait   = 0;
  int    fail_count   = 0;
  int    status_count = 0;

  lcd_mode_line_sequencer_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_line         (out_line),
    .out_mode         (out_mode),
    .out_coincidence  (out_coincidence),
    .out_stat_irq     (out_stat_irq),
    .out_vblank_irq   (out_vblank_irq),
    .out_hblank_start (out_hblank_start),
    .out_frame_ready  (out_frame_ready)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic int pick_wait(int odds);
    return ($urandom_range(0, 15) < odds) ? int'($urandom_range(0, WAIT_MAX)) : 0;
  endfunction

  function void stat_source(int en_bit);
    if (lcdc[7] && stat_en[en_bit]) stat_pulse = 1'b1;
  endfunction

  function void match_check();
    if (ly == lyc) begin
      stat_source(EN_LYC);
      ly_match = 1'b1;
    end else begin
      ly_match = 1'b0;
    end
  endfunction

  function void step_ly();
    ly = ly + 8'd1;
    ly = ly % LINE_COUNT;
    match_check();
  endfunction

  // Advance the predicted sequencer by one word and return the status word it yields.
  function res_t lcd_status_step(logic [2:0] act, logic [7:0] val);
    res_t       r;
    logic [7:0] mul;
    r = '0;
    stat_pulse = 1'b0;
    mul = (tick_scale == 2'd0) ? 8'd1 : (tick_scale == 2'd3) ? 8'd2 : {6'd0, tick_scale};
    case (act)
      ACT_TICK: begin
        if (lcd_phase != PH_OFF) begin
          if (ticks_left > 8'd1) begin
            ticks_left = ticks_left - 8'd1;
          end else begin
            case (lcd_phase)
              PH_OAM: begin
                lcd_phase  = PH_XFER;
                ticks_left = XFER_TICKS * mul;
              end
              PH_XFER: begin
                stat_source(EN_HBLANK);
                r.hblank_start = 1'b1;
                lcd_phase  = (ly == LINE_LAST_VIS) ? PH_HBL_VBL : PH_HBL_OAM;
                ticks_left = HBL_TICKS * mul;
              end
              PH_HBL_OAM, PH_VBL_OAM: begin
                step_ly();
                stat_source(EN_OAM);
                lcd_phase  = PH_OAM;
                ticks_left = OAM_TICKS * mul;
              end
              PH_HBL_VBL: begin
                step_ly();
                r.vblank_irq = 1'b1;
                stat_source(EN_VBLANK);
                r.frame_ready = 1'b1;
                lcd_phase  = PH_VBL_LINE;
                ticks_left = LINE_TICKS * mul;
              end
              default: begin
                step_ly();
                lcd_phase  = (ly == LINE_LAST) ? PH_VBL_OAM : PH_VBL_LINE;
                ticks_left = LINE_TICKS * mul;
              end
            endcase
          end
        end
      end
      ACT_CTRL: begin
        if (!(lcdc[7] && val[7])) begin
          if (val[7]) begin
            // display on: restart at line 0 with one tick less of OAM search
            ly = 8'hFF;
            step_ly();
            lcd_phase  = PH_OAM;
            ticks_left = OAM_TICKS * mul - 8'd1;
          end else if (lcdc[7]) begin
            ly = 8'd0;
            match_check();
            ly_match   = 1'b0;
            lcd_phase  = PH_OFF;
            ticks_left = 8'd0;
          end
        end
        lcdc = val;
      end
      ACT_CMP: begin
        lyc = val;
        match_check();
      end
      ACT_LINE_RST: begin
        ly = 8'd0;
        match_check();
      end
      ACT_STAT_EN: stat_en = val[6:3];
      default: ;
    endcase
    r.line  = ly;
    case (lcd_phase)
      PH_OAM:                  r.mode = MODE_OAM;
      PH_XFER:                 r.mode = MODE_XFER;
      PH_VBL_LINE, PH_VBL_OAM: r.mode = MODE_VBLANK;
      default:                 r.mode = MODE_HBLANK;
    endcase
    r.coinc    = ly_match;
    r.stat_req = stat_pulse;
    return r;
  endfunction

  function automatic word_t random_word();
    word_t   w;
    int unsigned pick;
    pick    = $urandom_range(0, 99);
    w.value = 8'($urandom);
    if (pick < 80) begin
      w.action = ACT_TICK;
    end else if (pick < 85) begin
      w.action = ACT_CMP;
      case ($urandom_range(0, 3))
        0, 1: w.value = 8'($urandom_range(0, 8));
        2:    w.value = 8'($urandom_range(LINE_LAST_VIS - 3, LINE_LAST));
        default: ;
      endcase
    end else if (pick < 89) begin
      w.action = ACT_STAT_EN;
    end else if (pick < 93) begin
      w.action   = ACT_CTRL;
      w.value[7] = ($urandom_range(0, 9) < 7);
    end else if (pick < 96) begin
      w.action = ACT_LINE_RST;
    end else begin
      w.action = 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
    end
    return w;
  endfunction

  task automatic push_word(logic [2:0] act, logic [7:0] val);
    pending_words.push_back('{act, val});
  endtask

  task automatic set_speed(logic [1:0] factor);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= factor;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tick_scale  = factor;
  endtask

  // Hold until every word is sent and every status word has come back.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || status_due.size() != 0);
  endtask

  // Driver: present the next pending word after its drawn gap; predict on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      feed_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        status_due.push_back(lcd_status_step(in_action, in_value));
        feed_wait = pick_wait(feed_odds);
      end
      if (!in_valid || !in_stall) begin
        if (feed_wait > 0) begin
          feed_wait--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          word_t w;
          w = pending_words.pop_front();
          in_valid  <= 1'b1;
          in_action <= w.action;
          in_value  <= w.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted status word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      drain_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        res_t got, want;
        got = '{out_line, out_mode, out_coincidence, out_stat_irq, out_vblank_irq,
                out_hblank_start, out_frame_ready};
        status_count++;
        if (status_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("status word %0d arrived with nothing predicted: line %0d mode %0d",
                     status_count, got.line, got.mode);
        end else begin
          want = status_due.pop_front();
          if (got.line != want.line || got.mode != want.mode || got.coinc != want.coinc ||
              got.stat_req != want.stat_req || got.vblank_irq != want.vblank_irq ||
              got.hblank_start != want.hblank_start ||
              got.frame_ready != want.frame_ready) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"status word %0d mismatch (line mode coinc stat vbl hbl frame):",
                        " expected %0d %0d %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d %0d %0d"},
                       status_count, want.line, want.mode, want.coinc, want.stat_req,
                       want.vblank_irq, want.hblank_start, want.frame_ready,
                       got.line, got.mode, got.coinc, got.stat_req,
                       got.vblank_irq, got.hblank_start, got.frame_ready);
          end
        end
        drain_wait = pick_wait(drain_odds);
      end
      if (drain_wait > 0) begin
        drain_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [1:0] speed_plan[4];
    int         feed_plan[4];
    int         drain_plan[4];
    int unsigned pick;
    speed_plan = '{2'd2, 2'd0, 2'd3, 2'd1};
    feed_plan  = '{16, 4, 0, 10};
    drain_plan = '{16, 0, 0, 16};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed: unused actions, compare hits, display off and on, value extremes
    set_speed(2'd1);
    @(negedge clk);
    push_word(ACT_TICK, 8'h00);
    push_word(ACT_TICK, 8'hFF);
    push_word(ACT_UNUSED_FIRST, 8'hFF);
    push_word(3'd6, 8'h00);
    push_word(ACT_UNUSED_LAST, 8'hAA);
    push_word(ACT_STAT_EN, 8'hFF);
    push_word(ACT_CMP, LINE_VBL_FIRST);
    push_word(ACT_TICK, 8'h55);
    push_word(ACT_LINE_RST, 8'hFF);
    push_word(ACT_CMP, 8'h00);
    push_word(ACT_CTRL, 8'h93);
    push_word(ACT_CTRL, 8'h13);
    push_word(ACT_TICK, 8'h00);
    push_word(ACT_LINE_RST, 8'h00);
    push_word(ACT_CMP, 8'hFF);
    push_word(ACT_CTRL, 8'h00);
    push_word(ACT_CTRL, 8'hFF);
    push_word(ACT_CMP, 8'h00);
    push_word(ACT_STAT_EN, 8'h00);
    push_word(ACT_STAT_EN, 8'h78);
    wait_idle();

    // a long run of ticks through the OAM, transfer and hblank modes of a few lines
    feed_odds  = 1;
    drain_odds = 1;
    for (int i = 0; i < TICK_RUN; i++) begin
      pick = $urandom_range(0, 399);
      if (pick == 0)
        push_word(ACT_STAT_EN, 8'($urandom));
      else if (pick < 3)
        push_word(ACT_CMP, 8'($urandom_range(0, LINE_LAST)));
      else
        push_word(ACT_TICK, 8'($urandom));
    end
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      set_speed(speed_plan[p]);
      @(negedge clk);
      feed_odds  = feed_plan[p];
      drain_odds = drain_plan[p];
      for (int i = 0; i < RANDOM_WORDS; i++) pending_words.push_back(random_word());
      wait_idle();
    end

    repeat (8) @(posedge clk);
    fail_count += status_due.size();
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> lcd_mode_line_sequencer_core.f
rtl/lmls_pkg.sv
rtl/lmls_step.sv
rtl/lcd_mode_line_sequencer_core.sv
verif/tb.sv
